// ===== design/tkps_pkg.sv =====
// ----------------------------------------------------------------------------
// tkps_pkg
// Types and constants shared by the top-k pair sums block.
// ----------------------------------------------------------------------------
package tkps_pkg;

  localparam int VAL_W = 16;
  localparam int SUM_W = VAL_W + 1;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [VAL_W-1:0] elem_first;
    logic [VAL_W-1:0] elem_second;
    logic             last_pair;
    logic [CNT_W-1:0] top_count;
  } pair_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] pair_sum;
    logic             last_sum;
  } sum_item_t;

  // front to back: a finished, sorted load waiting for the back end
  typedef struct packed {
    logic             pending;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
    logic [VAL_W-1:0] head_first;
    logic [VAL_W-1:0] head_second;
  } run_req_t;

  // back to front: drain control
  typedef struct packed {
    logic shift;
    logic done;
  } run_ack_t;

endpackage

// ===== design/top_k_pair_sums.sv =====
// ----------------------------------------------------------------------------
// top_k_pair_sums
// Emits the k largest sums of one element from each of two loaded arrays.
// ----------------------------------------------------------------------------
// Pairs are taken one per cycle, while full is low, into an insertion sorter.
// After the pair marked last, full stays high while the back end picks up
// the load and then copies the sorted load into the back end RAMs (n = pairs
// loaded, at most MAX_LEN). It stays high longer while the back end still
// finishes an earlier run. Then the next load may start while the run goes
// on. Each sum of the run is found by a scan over k row pointers through
// registered RAM reads; k is top_count clamped to n and a run gives k sums,
// the last one flagged.
module top_k_pair_sums #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tkps_pkg::pair_item_t pair,
  output logic                 empty,
  input  logic                 pop,
  output tkps_pkg::sum_item_t  result
);
  import tkps_pkg::*;

  run_req_t req;
  run_ack_t ack;

  tkps_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .pair(pair),
    .req(req), .ack(ack)
  );

  tkps_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk(clk), .rst(rst), .req(req), .ack(ack),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule

// ===== design/tkps_ram.sv =====
// ----------------------------------------------------------------------------
// tkps_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tkps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tkps_front.sv =====
// ----------------------------------------------------------------------------
// tkps_front
// Accepts pairs and keeps both arrays in descending order with an insertion
// sorter, then drains them head first to the back end.
// ----------------------------------------------------------------------------
module tkps_front #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tkps_pkg::pair_item_t pair,
  output tkps_pkg::run_req_t  req,
  input  tkps_pkg::run_ack_t  ack
);
  import tkps_pkg::*;

  logic [VAL_W-1:0] va [MAX_LEN];
  logic [VAL_W-1:0] vb [MAX_LEN];
  logic [VAL_W-1:0] va_next [MAX_LEN];
  logic [VAL_W-1:0] vb_next [MAX_LEN];
  logic [CNT_W-1:0] count;
  logic             pending;
  logic [CNT_W-1:0] run_n;
  logic [CNT_W-1:0] run_k;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] n_new;
  logic [MAX_LEN-1:0] ge_a;
  logic [MAX_LEN-1:0] ge_b;

  assign full   = pending;
  assign accept = push && !pending;
  assign room   = count < CNT_W'(MAX_LEN);
  assign n_new  = room ? count + CNT_W'(1) : count;

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      ge_a[i] = (CNT_W'(i) < count) && (va[i] >= pair.elem_first);
      ge_b[i] = (CNT_W'(i) < count) && (vb[i] >= pair.elem_second);
    end
    for (int i = 0; i < MAX_LEN; i++) begin
      if (ack.shift) begin
        va_next[i] = (i < MAX_LEN - 1) ? va[(i < MAX_LEN - 1) ? i + 1 : i] : va[i];
        vb_next[i] = (i < MAX_LEN - 1) ? vb[(i < MAX_LEN - 1) ? i + 1 : i] : vb[i];
      end else if (accept && room) begin
        if (ge_a[i]) begin
          va_next[i] = va[i];
        end else if (i == 0 || ge_a[(i > 0) ? i - 1 : 0]) begin
          va_next[i] = pair.elem_first;
        end else begin
          va_next[i] = va[(i > 0) ? i - 1 : 0];
        end
        if (ge_b[i]) begin
          vb_next[i] = vb[i];
        end else if (i == 0 || ge_b[(i > 0) ? i - 1 : 0]) begin
          vb_next[i] = pair.elem_second;
        end else begin
          vb_next[i] = vb[(i > 0) ? i - 1 : 0];
        end
      end else begin
        va_next[i] = va[i];
        vb_next[i] = vb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      va[i] <= va_next[i];
      vb[i] <= vb_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= 1'b0;
      run_n   <= '0;
      run_k   <= '0;
    end else begin
      if (ack.done) begin
        pending <= 1'b0;
      end
      if (accept) begin
        if (pair.last_pair) begin
          count   <= '0;
          pending <= 1'b1;
          run_n   <= n_new;
          run_k   <= (pair.top_count > n_new) ? n_new : pair.top_count;
        end else if (room) begin
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  assign req.pending     = pending;
  assign req.n           = run_n;
  assign req.k           = run_k;
  assign req.head_first  = va[0];
  assign req.head_second = vb[0];

endmodule

// ===== design/tkps_back.sv =====
// ----------------------------------------------------------------------------
// tkps_back
// Copies a sorted load into RAM, then picks each next largest sum by scanning
// the column pointers of the first k rows of the first array.
// ----------------------------------------------------------------------------
module tkps_back #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  tkps_pkg::run_req_t  req,
  output tkps_pkg::run_ack_t  ack,
  output logic                empty,
  input  logic                pop,
  output tkps_pkg::sum_item_t result
);
  import tkps_pkg::*;

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COPY  = 3'd1;
  localparam logic [2:0] ST_SCAN0 = 3'd2;
  localparam logic [2:0] ST_SCAN1 = 3'd3;
  localparam logic [2:0] ST_SCAN2 = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] emitted;
  logic             best_valid;
  logic [SUM_W-1:0] best_sum;
  logic [CNT_W-1:0] best_row;
  logic [CNT_W-1:0] best_ptr;
  logic             out_valid;
  sum_item_t        out_item;

  logic             a_we, b_we, p_we, a_re, b_re, p_re;
  logic [IDX_W-1:0] a_waddr, p_waddr, a_raddr, b_raddr, p_raddr;
  logic [CNT_W-1:0] p_wdata;
  logic [VAL_W-1:0] a_rdata, b_rdata;
  logic [CNT_W-1:0] p_rdata;
  logic [SUM_W-1:0] cand_sum;

  assign cand_sum = SUM_W'(a_rdata) + SUM_W'(b_rdata);

  always_comb begin
    a_we    = (state == ST_COPY);
    b_we    = (state == ST_COPY);
    a_waddr = idx[IDX_W-1:0];
    p_we    = (state == ST_COPY) || (state == ST_EMIT && !out_valid);
    p_waddr = (state == ST_COPY) ? idx[IDX_W-1:0] : best_row[IDX_W-1:0];
    p_wdata = (state == ST_COPY) ? '0 : best_ptr + CNT_W'(1);
    a_re    = (state == ST_SCAN0);
    p_re    = (state == ST_SCAN0);
    a_raddr = idx[IDX_W-1:0];
    p_raddr = idx[IDX_W-1:0];
    b_re    = (state == ST_SCAN1);
    b_raddr = p_rdata[IDX_W-1:0];
  end

  tkps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(req.head_first),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  tkps_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk(clk), .we(b_we), .waddr(a_waddr), .wdata(req.head_second),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  tkps_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_ptr_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  assign ack.shift = (state == ST_COPY);
  assign ack.done  = (state == ST_COPY) && (idx == n - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      emitted    <= '0;
      best_valid <= 1'b0;
      out_valid  <= 1'b0;
      n          <= '0;
      k          <= '0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.pending) begin
            n     <= req.n;
            k     <= req.k;
            idx   <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (idx == n - CNT_W'(1)) begin
            idx        <= '0;
            emitted    <= '0;
            best_valid <= 1'b0;
            state      <= (k == '0) ? ST_IDLE : ST_SCAN0;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        ST_SCAN0: state <= ST_SCAN1;
        ST_SCAN1: state <= ST_SCAN2;
        ST_SCAN2: begin
          // row still has a column left
          if (p_rdata < n && (!best_valid || cand_sum > best_sum)) begin
            best_valid <= 1'b1;
            best_sum   <= cand_sum;
            best_row   <= idx;
            best_ptr   <= p_rdata;
          end
          if (idx == k - CNT_W'(1)) begin
            state <= ST_EMIT;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= ST_SCAN0;
          end
        end
        ST_EMIT: begin
          if (!out_valid) begin
            out_valid         <= 1'b1;
            out_item.pair_sum <= best_sum;
            out_item.last_sum <= (emitted == k - CNT_W'(1));
            emitted           <= emitted + CNT_W'(1);
            idx               <= '0;
            best_valid        <= 1'b0;
            state <= (emitted == k - CNT_W'(1)) ? ST_IDLE : ST_SCAN0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign empty  = !out_valid;
  assign result = out_item;

endmodule

// ===== design/tkps_checker.sv =====
// ----------------------------------------------------------------------------
// tkps_checker
// Port level checks on the result stream of the top-k pair sums block.
// ----------------------------------------------------------------------------
module tkps_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 push,
  input logic                 full,
  input tkps_pkg::pair_item_t pair,
  input logic                 empty,
  input logic                 pop,
  input tkps_pkg::sum_item_t  result
);
  import tkps_pkg::*;

  logic             in_run;
  logic [SUM_W-1:0] prev_sum;
  logic [CNT_W-1:0] run_cnt;
  logic             taken;

  assign taken = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run  <= 1'b0;
      run_cnt <= '0;
    end else if (taken) begin
      in_run   <= !result.last_sum;
      prev_sum <= result.pair_sum;
      run_cnt  <= result.last_sum ? '0 : run_cnt + CNT_W'(1);
    end
  end

  // sums of one run never grow
  a_non_increasing: assert property (@(posedge clk) disable iff (rst)
    (taken && in_run) |-> (result.pair_sum <= prev_sum))
    else $error("pair sum increased within a run");

  // a run never exceeds the longest load
  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (taken && run_cnt == CNT_W'(63)) |-> result.last_sum)
    else $error("run longer than the store");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind top_k_pair_sums tkps_checker u_tkps_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .pair(pair),
  .empty(empty), .pop(pop), .result(result)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed check of top_k_pair_sums against an in-bench predictor.
// ----------------------------------------------------------------------------
// Pairs are loaded as arrays of directed or random length, each closed by a
// last pair that carries the wanted count. The predictor sorts all pair sums
// of both arrays and keeps the k largest; each result item is compared in order.
module testbench;
  import tkps_pkg::*;

  localparam int MAXN = 64;
  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full, empty;
  pair_item_t pair = '0;
  sum_item_t  result;

  top_k_pair_sums #(.MAX_LEN(MAXN)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .pair(pair),
    .empty(empty), .pop(pop), .result(result)
  );

  always #4 clk = ~clk;

  pair_item_t pending_pairs[$];
  sum_item_t  expected_sums[$];
  logic [VAL_W-1:0] load_first[$];
  logic [VAL_W-1:0] load_second[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 0;
  int  hold_off = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  accepted = 0;
  bit  took = 0;

  // k largest sums by brute force over the full n x n grid
  task automatic predict_run(input int k_in);
    int n, k, i, j, c;
    int sums[$];
    sum_item_t s;
    n = load_first.size();
    k = (k_in > n) ? n : k_in;
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++)
        sums.insert(sums.size(), int'(load_first[i]) + int'(load_second[j]));
    sums.rsort();
    for (c = 0; c < k; c++) begin
      s.pair_sum = SUM_W'(sums[c]);
      s.last_sum = (c == k - 1);
      expected_sums.insert(expected_sums.size(), s);
    end
    load_first.delete();
    load_second.delete();
  endtask

  task automatic account(input pair_item_t p);
    if (load_first.size() < MAXN) begin
      load_first.insert(load_first.size(), p.elem_first);
      load_second.insert(load_second.size(), p.elem_second);
    end
    if (p.last_pair) predict_run(p.top_count);
  endtask

  function automatic logic [VAL_W-1:0] rand_val(input int mode);
    case (mode)
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(3));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic add_load(input int n, input int k, input int mode);
    pair_item_t p;
    int i;
    for (i = 0; i < n; i++) begin
      p.elem_first = rand_val(mode);
      p.elem_second = rand_val(mode);
      p.last_pair = (i == n - 1);
      p.top_count = (i == n - 1) ? k[CNT_W-1:0] : CNT_W'($urandom);
      pending_pairs.insert(pending_pairs.size(), p);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!push || took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          pair <= pending_pairs.pop_front();
          push <= 1'b1;
          if (!calm && $urandom_range(9) == 0) send_gap <= $urandom_range(1, 14);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off right after reset
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off < HOLD_CYCLES) begin
        hold_off <= hold_off + 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(9) == 0) recv_gap <= $urandom_range(1, 14);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    took <= 1'b0;
    if (!rst) begin
      if (push && !full) begin
        account(pair);
        accepted <= accepted + 1;
        took <= 1'b1;
      end
      if (pop && !empty) begin
        if (expected_sums.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected sum %0d last %0b", result.pair_sum,
                                    result.last_sum);
        end else begin
          sum_item_t e;
          e = expected_sums.pop_front();
          if (e !== result) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp sum %0d last %0b, got sum %0d last %0b",
                       e.pair_sum, e.last_sum, result.pair_sum, result.last_sum);
          end
        end
      end
    end
  end

  initial begin
    int r, n, m;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: extremes, single pair, zero count, clamp, ties, overfull load
    add_load(1, 1, 1);
    add_load(1, 0, 3);
    add_load(4, 64, 0);
    add_load(3, 2, 1);
    add_load(5, 127, 2);
    add_load(70, 64, 3);
    add_load(2, 1, 1);
    // loads that keep coming while the receiver holds off
    for (r = 0; r < 3; r++) add_load($urandom_range(2, 8), 8, 3);
    // random loads, mostly short, a few long ones up to full size
    m = 0;
    while (m < 400) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 10);
      add_load(n, $urandom_range(19) == 0 ? 0 : $urandom_range(1, 70),
               $urandom_range(9) < 2 ? 2 : 3);
      m += n;
    end
    while (pending_pairs.size() >= 30) @(posedge clk);
    calm = 1;
    while (pending_pairs.size() != 0 || push) @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 800000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
